@@ design/ymodem_crc_block_sender_core_defines.svh @@
// assertion macros shared by the sender core
`ifndef YMODEM_CRC_BLOCK_SENDER_CORE_DEFINES_SVH
`define YMODEM_CRC_BLOCK_SENDER_CORE_DEFINES_SVH

// implication checked at every clock edge outside reset
`define YCSB_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sender core check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define YCSB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sender core check failed");

`endif

@@ design/ycsb_pkg.sv @@
// shared types, constants and crc function of the ymodem sender core
package ycsb_pkg;

	localparam int LARGE_BLOCK_BYTES = 1024;
	localparam int SMALL_BLOCK_BYTES = 128;
	localparam int CNT_W  = $clog2(LARGE_BLOCK_BYTES) + 1;
	localparam int ADDR_W = $clog2(LARGE_BLOCK_BYTES);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_SOH  = 8'h01;
	localparam logic [7:0] BYTE_STX  = 8'h02;
	localparam logic [7:0] BYTE_EOT  = 8'h04;
	localparam logic [7:0] BYTE_ACK  = 8'h06;
	localparam logic [7:0] BYTE_C    = 8'h43;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [15:0] READY_TIMEOUT_RST = 16'd10000;
	localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd5000;

	// input mode codes
	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_RX      = 3'd1;
	localparam logic [2:0] MODE_PAYLOAD = 3'd2;
	localparam logic [2:0] MODE_EOF     = 3'd3;
	localparam logic [2:0] MODE_PULL    = 3'd4;
	localparam logic [2:0] MODE_RESTART = 3'd5;

	// configuration register indexes
	localparam logic REG_READY_TIMEOUT = 1'b0;
	localparam logic REG_ACK_TIMEOUT   = 1'b1;

	localparam logic [1:0] STATUS_BUSY = 2'd0;
	localparam logic [1:0] STATUS_DONE = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	localparam logic [2:0] CAUSE_NONE       = 3'd0;
	localparam logic [2:0] CAUSE_NOT_READY  = 3'd1;
	localparam logic [2:0] CAUSE_HEADER_ACK = 3'd2;
	localparam logic [2:0] CAUSE_DATA_ACK   = 3'd3;
	localparam logic [2:0] CAUSE_EOT_ACK    = 3'd4;

	typedef enum logic [1:0] {
		CTX_FINAL, CTX_HEADER, CTX_DATA, CTX_EOT
	} ctx_t;

	typedef enum logic [2:0] {
		PH_LOAD_HEADER, PH_WAIT_READY, PH_SEND_FRAME, PH_WAIT_ACK,
		PH_LOAD_CHUNK, PH_SEND_EOT, PH_DONE, PH_FAILED
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NOP, CMD_TICK, CMD_RX_C, CMD_RX_ACK, CMD_PAYLOAD,
		CMD_EOF, CMD_PULL, CMD_RESTART
	} cmd_t;

	typedef struct packed {
		cmd_t       kind;
		logic [7:0] value;
		logic       last;
	} word_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] status;
		logic [2:0] fail_cause;
	} result_t;

	// crc-16/xmodem update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

@@ design/ycsb_ram.sv @@
// generic single write port ram with registered read
module ycsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/ycsb_front.sv @@
// front end: input handshake and classification of words into commands
module ycsb_front import ycsb_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [7:0] value,
	input  logic       last,
	input  logic       q_full,
	output logic       push,
	output word_t      push_word
);

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// classify the word
	always_comb begin
		push_word.value = value;
		push_word.last  = last;
		case (mode)
			MODE_TICK:    push_word.kind = CMD_TICK;
			MODE_RX: begin
				if (value == BYTE_C) begin
					push_word.kind = CMD_RX_C;
				end else if (value == BYTE_ACK) begin
					push_word.kind = CMD_RX_ACK;
				end else begin
					push_word.kind = CMD_NOP;
				end
			end
			MODE_PAYLOAD: push_word.kind = CMD_PAYLOAD;
			MODE_EOF:     push_word.kind = CMD_EOF;
			MODE_PULL:    push_word.kind = CMD_PULL;
			MODE_RESTART: push_word.kind = CMD_RESTART;
			default:      push_word.kind = CMD_NOP;
		endcase
	end

endmodule

@@ design/ycsb_queue.sv @@
// two-entry command queue between front and back
module ycsb_queue import ycsb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  word_t push_word,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output word_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	word_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [PTR_W:0]     count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_word;
		end
	end

endmodule

@@ design/ycsb_back.sv @@
// back end: protocol engine, chunk buffer, crc and output register
module ycsb_back import ycsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] ready_timeout,
	input  logic [15:0] ack_timeout,
	input  logic        q_not_empty,
	input  word_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result
);

	phase_t             phase_q, phase_n;
	ctx_t               ctx_q, ctx_n;
	logic [7:0]         bn_q, bn_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [CNT_W-1:0]   emit_q, emit_n;
	logic [15:0]        crc_q, crc_n;
	logic [15:0]        wt_q, wt_n;
	logic               large_q, large_n;
	logic [2:0]         fail_q, fail_n;
	logic               out_valid_q;
	result_t            result_q, result_n;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [7:0]         mem_rdata;
	logic               go;
	logic               tx_v;
	logic [7:0]         tx_b;

	assign go        = q_not_empty && (!out_valid_q || out_ready);
	assign pop       = go;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// prefetch the payload byte for the next emit position
	assign mem_raddr = ADDR_W'(emit_n - CNT_W'(3));
	assign mem_we    = go && (head.kind == CMD_PAYLOAD)
		&& ((phase_q == PH_LOAD_HEADER && cnt_q < CNT_W'(SMALL_BLOCK_BYTES))
		|| (phase_q == PH_LOAD_CHUNK && cnt_q < CNT_W'(LARGE_BLOCK_BYTES)));

	ycsb_ram #(.WIDTH(8), .DEPTH(LARGE_BLOCK_BYTES)) u_chunk_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (head.value),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		logic [15:0]      wt_inc;
		logic [15:0]      limit;
		logic [2:0]       cause;
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] cnt_inc;
		logic [7:0]       b;
		phase_n = phase_q;
		ctx_n   = ctx_q;
		bn_n    = bn_q;
		cnt_n   = cnt_q;
		emit_n  = emit_q;
		crc_n   = crc_q;
		wt_n    = wt_q;
		large_n = large_q;
		fail_n  = fail_q;
		tx_v    = 1'b0;
		tx_b    = 8'h00;
		wt_inc  = (wt_q == 16'hFFFF) ? wt_q : wt_q + 16'd1;
		len     = large_q ? CNT_W'(LARGE_BLOCK_BYTES) : CNT_W'(SMALL_BLOCK_BYTES);
		k       = emit_q - CNT_W'(3);
		cnt_inc = mem_we ? cnt_q + 1'b1 : cnt_q;
		b       = 8'h00;
		limit   = ack_timeout;
		cause   = CAUSE_EOT_ACK;
		case (ctx_q)
			CTX_HEADER: cause = CAUSE_HEADER_ACK;
			CTX_DATA:   cause = CAUSE_DATA_ACK;
			default:    cause = CAUSE_EOT_ACK;
		endcase
		if (phase_q == PH_WAIT_READY) begin
			limit = ready_timeout;
			cause = CAUSE_NOT_READY;
		end
		if (go) begin
			case (head.kind)
				CMD_TICK: begin
					if (phase_q == PH_WAIT_READY || phase_q == PH_WAIT_ACK) begin
						wt_n = wt_inc;
						if (wt_inc >= limit) begin
							fail_n  = cause;
							phase_n = PH_FAILED;
						end
					end
				end
				CMD_RX_C: begin
					if (phase_q == PH_WAIT_READY) begin
						bn_n    = 8'h00;
						large_n = 1'b0;
						phase_n = PH_SEND_FRAME;
						ctx_n   = CTX_HEADER;
						emit_n  = '0;
						crc_n   = '0;
					end
				end
				CMD_RX_ACK: begin
					if (phase_q == PH_WAIT_ACK) begin
						case (ctx_q)
							CTX_HEADER: begin
								bn_n    = 8'h01;
								cnt_n   = '0;
								phase_n = PH_LOAD_CHUNK;
							end
							CTX_DATA: begin
								bn_n    = bn_q + 8'h01;
								cnt_n   = '0;
								phase_n = PH_LOAD_CHUNK;
							end
							default: begin
								bn_n    = 8'h00;
								cnt_n   = '0;
								large_n = 1'b0;
								phase_n = PH_SEND_FRAME;
								ctx_n   = CTX_FINAL;
								emit_n  = '0;
								crc_n   = '0;
							end
						endcase
					end
				end
				CMD_PAYLOAD: begin
					if (phase_q == PH_LOAD_HEADER || phase_q == PH_LOAD_CHUNK) begin
						cnt_n = cnt_inc;
						if (head.last) begin
							if (phase_q == PH_LOAD_HEADER) begin
								phase_n = PH_WAIT_READY;
								wt_n    = '0;
							end else begin
								large_n = (cnt_inc > CNT_W'(SMALL_BLOCK_BYTES));
								phase_n = PH_SEND_FRAME;
								ctx_n   = CTX_DATA;
								emit_n  = '0;
								crc_n   = '0;
							end
						end
					end
				end
				CMD_EOF: begin
					if (phase_q == PH_LOAD_CHUNK && cnt_q == '0) begin
						phase_n = PH_SEND_EOT;
					end
				end
				CMD_PULL: begin
					if (phase_q == PH_SEND_EOT) begin
						tx_v    = 1'b1;
						tx_b    = BYTE_EOT;
						ctx_n   = CTX_EOT;
						phase_n = PH_WAIT_ACK;
						wt_n    = '0;
					end else if (phase_q == PH_SEND_FRAME) begin
						tx_v = 1'b1;
						if (emit_q == CNT_W'(0)) begin
							b     = large_q ? BYTE_STX : BYTE_SOH;
							crc_n = '0;
						end else if (emit_q == CNT_W'(1)) begin
							b = bn_q;
						end else if (emit_q == CNT_W'(2)) begin
							b = ~bn_q;
						end else if (emit_q < len + CNT_W'(3)) begin
							b     = (k < cnt_q) ? mem_rdata : 8'h00;
							crc_n = crc_byte(crc_q, b);
						end else if (emit_q == len + CNT_W'(3)) begin
							b = crc_q[15:8];
						end else begin
							b = crc_q[7:0];
						end
						tx_b = b;
						if (emit_q >= len + CNT_W'(4)) begin
							if (ctx_q == CTX_FINAL) begin
								phase_n = PH_DONE;
							end else begin
								phase_n = PH_WAIT_ACK;
								wt_n    = '0;
							end
						end else begin
							emit_n = emit_q + 1'b1;
						end
					end
				end
				CMD_RESTART: begin
					phase_n = PH_LOAD_HEADER;
					bn_n    = '0;
					cnt_n   = '0;
					emit_n  = '0;
					crc_n   = '0;
					wt_n    = '0;
					large_n = 1'b0;
					ctx_n   = CTX_FINAL;
					fail_n  = CAUSE_NONE;
				end
				default: begin
				end
			endcase
		end
	end

	// result word
	always_comb begin
		result_n.tx_valid   = tx_v;
		result_n.tx_byte    = tx_b;
		result_n.fail_cause = fail_n;
		case (phase_n)
			PH_DONE:   result_n.status = STATUS_DONE;
			PH_FAILED: result_n.status = STATUS_FAIL;
			default:   result_n.status = STATUS_BUSY;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LOAD_HEADER;
			ctx_q       <= CTX_FINAL;
			bn_q        <= '0;
			cnt_q       <= '0;
			emit_q      <= '0;
			crc_q       <= '0;
			wt_q        <= '0;
			large_q     <= 1'b0;
			fail_q      <= CAUSE_NONE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			ctx_q   <= ctx_n;
			bn_q    <= bn_n;
			cnt_q   <= cnt_n;
			emit_q  <= emit_n;
			crc_q   <= crc_n;
			wt_q    <= wt_n;
			large_q <= large_n;
			fail_q  <= fail_n;
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (go) begin
			result_q <= result_n;
		end
	end

endmodule

@@ design/ymodem_crc_block_sender_core.sv @@
// Top level of the YMODEM sender with CRC-16/XMODEM framing. Every input word
// (tick, received byte, payload byte, end of file, transmit pull, restart)
// yields exactly one output word with tx_valid, tx_byte, status and
// fail_cause. Words go through a two-entry command queue into the engine,
// which retires one word per cycle while the output register is free, so a
// steady stream runs at one word per clock; each output word is registered
// in the output register after its input word has left the queue. The
// 1024-byte chunk buffer is one RAM with a registered read port that is
// addressed one pull ahead of the emit position.
// Configuration registers (index 0 ready timeout, index 1 ack timeout) are to be
// written by the user only while the block is idle; the block does not enforce it.
`include "ymodem_crc_block_sender_core_defines.svh"
module ymodem_crc_block_sender_core import ycsb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic [1:0]  status,
	output logic [2:0]  fail_cause,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] ready_timeout_q;
	logic [15:0] ack_timeout_q;
	logic        q_full;
	logic        q_not_empty;
	logic        push;
	logic        pop;
	word_t       push_word;
	word_t       head;
	result_t     result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_timeout_q <= READY_TIMEOUT_RST;
			ack_timeout_q   <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_READY_TIMEOUT) begin
				ready_timeout_q <= cfg_data;
			end else begin
				ack_timeout_q <= cfg_data;
			end
		end
	end

	ycsb_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.last      (last),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	ycsb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	ycsb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.ready_timeout (ready_timeout_q),
		.ack_timeout   (ack_timeout_q),
		.q_not_empty   (q_not_empty),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result)
	);

	// output fields
	assign tx_valid   = result.tx_valid;
	assign tx_byte    = result.tx_byte;
	assign status     = result.status;
	assign fail_cause = result.fail_cause;

	// checks
	`YCSB_ASSERT_IMPLIES(a_idle_byte_zero, out_valid && !tx_valid, tx_byte == 8'h00)
	`YCSB_ASSERT_IMPLIES(a_busy_no_cause, out_valid && status != STATUS_FAIL,
		fail_cause == CAUSE_NONE)
	`YCSB_ASSERT_IMPLIES(a_fail_has_cause, out_valid && status == STATUS_FAIL,
		fail_cause != CAUSE_NONE)
	`YCSB_ASSERT_NEXT(a_pop_fills_out, pop, out_valid)

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the ymodem crc block sender core
`timescale 1ns / 100ps
module testbench;
	import ycsb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [7:0]  value;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [1:0]  status;
	logic [2:0]  fail_cause;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	ymodem_crc_block_sender_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .value(value), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.tx_valid(tx_valid), .tx_byte(tx_byte), .status(status), .fail_cause(fail_cause),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// sender model state
	phase_t      sm_phase;
	logic [7:0]  sm_block;
	logic [7:0]  sm_chunk [LARGE_BLOCK_BYTES];
	int          sm_loaded;
	int          sm_emit;
	logic [15:0] sm_crc;
	logic [15:0] sm_wait;
	logic        sm_large;
	ctx_t        sm_ctx;
	logic [2:0]  sm_cause;
	logic [15:0] sm_ready_to;
	logic [15:0] sm_ack_to;

	result_t expected_words[$];
	int      errors;
	int      words_sent;
	int      idle_cycles;
	bit      quiet;
	bit      hold_req;

	// clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// bitwise crc-16/xmodem over one byte, msb first
	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void clear_sender();
		sm_phase = PH_LOAD_HEADER;
		sm_block = 8'd0;
		sm_loaded = 0;
		sm_emit = 0;
		sm_crc = 16'd0;
		sm_wait = 16'd0;
		sm_large = 1'b0;
		sm_ctx = CTX_FINAL;
		sm_cause = CAUSE_NONE;
	endfunction

	function automatic void open_frame(input ctx_t c);
		sm_phase = PH_SEND_FRAME;
		sm_ctx = c;
		sm_emit = 0;
		sm_crc = 16'd0;
	endfunction

	// next output word of the sender for one input word
	function automatic result_t predict_word(input logic [2:0] m, input logic [7:0] v,
			input logic l);
		result_t r;
		int flen;
		int cap;
		logic [7:0] b;
		r = '0;
		case (m)
			MODE_TICK: begin
				if (sm_phase == PH_WAIT_READY || sm_phase == PH_WAIT_ACK) begin
					if (sm_wait != 16'hFFFF)
						sm_wait = sm_wait + 16'd1;
					if (sm_phase == PH_WAIT_READY) begin
						if (sm_wait >= sm_ready_to) begin
							sm_cause = CAUSE_NOT_READY;
							sm_phase = PH_FAILED;
						end
					end else if (sm_wait >= sm_ack_to) begin
						sm_cause = (sm_ctx == CTX_HEADER) ? CAUSE_HEADER_ACK :
							(sm_ctx == CTX_DATA) ? CAUSE_DATA_ACK : CAUSE_EOT_ACK;
						sm_phase = PH_FAILED;
					end
				end
			end
			MODE_RX: begin
				if (sm_phase == PH_WAIT_READY && v == BYTE_C) begin
					sm_block = 8'd0;
					sm_large = 1'b0;
					open_frame(CTX_HEADER);
				end else if (sm_phase == PH_WAIT_ACK && v == BYTE_ACK) begin
					if (sm_ctx == CTX_HEADER || sm_ctx == CTX_DATA) begin
						sm_block = (sm_ctx == CTX_HEADER) ? 8'd1 : sm_block + 8'd1;
						sm_loaded = 0;
						sm_phase = PH_LOAD_CHUNK;
					end else begin
						sm_block = 8'd0;
						sm_loaded = 0;
						sm_large = 1'b0;
						open_frame(CTX_FINAL);
					end
				end
			end
			MODE_PAYLOAD: begin
				if (sm_phase == PH_LOAD_HEADER || sm_phase == PH_LOAD_CHUNK) begin
					cap = (sm_phase == PH_LOAD_HEADER) ? SMALL_BLOCK_BYTES : LARGE_BLOCK_BYTES;
					if (sm_loaded < cap) begin
						sm_chunk[sm_loaded] = v;
						sm_loaded++;
					end
					if (l) begin
						if (sm_phase == PH_LOAD_HEADER) begin
							sm_phase = PH_WAIT_READY;
							sm_wait = 16'd0;
						end else begin
							sm_large = (sm_loaded > SMALL_BLOCK_BYTES);
							open_frame(CTX_DATA);
						end
					end
				end
			end
			MODE_EOF: begin
				if (sm_phase == PH_LOAD_CHUNK && sm_loaded == 0)
					sm_phase = PH_SEND_EOT;
			end
			MODE_PULL: begin
				if (sm_phase == PH_SEND_EOT) begin
					r.tx_valid = 1'b1;
					r.tx_byte = BYTE_EOT;
					sm_ctx = CTX_EOT;
					sm_phase = PH_WAIT_ACK;
					sm_wait = 16'd0;
				end else if (sm_phase == PH_SEND_FRAME) begin
					flen = sm_large ? LARGE_BLOCK_BYTES : SMALL_BLOCK_BYTES;
					if (sm_emit == 0) begin
						b = sm_large ? BYTE_STX : BYTE_SOH;
						sm_crc = 16'd0;
					end else if (sm_emit == 1) begin
						b = sm_block;
					end else if (sm_emit == 2) begin
						b = ~sm_block;
					end else if (sm_emit < flen + 3) begin
						b = (sm_emit - 3 < sm_loaded) ? sm_chunk[sm_emit - 3] : 8'd0;
						sm_crc = crc_update(sm_crc, b);
					end else if (sm_emit == flen + 3) begin
						b = sm_crc[15:8];
					end else begin
						b = sm_crc[7:0];
					end
					r.tx_valid = 1'b1;
					r.tx_byte = b;
					if (sm_emit >= flen + 4) begin
						if (sm_ctx == CTX_FINAL) begin
							sm_phase = PH_DONE;
						end else begin
							sm_phase = PH_WAIT_ACK;
							sm_wait = 16'd0;
						end
					end else begin
						sm_emit++;
					end
				end
			end
			MODE_RESTART: clear_sender();
			default: ;
		endcase
		r.status = (sm_phase == PH_DONE) ? STATUS_DONE :
			(sm_phase == PH_FAILED) ? STATUS_FAIL : STATUS_BUSY;
		r.fail_cause = sm_cause;
		return r;
	endfunction

	// offer one word, at times with a random gap ahead of it
	task automatic send_word(input logic [2:0] m, input logic [7:0] v, input logic l);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		last <= l;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(predict_word(m, v, l));
		words_sent++;
	endtask

	// drop the input and let every expected word arrive before going on
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic idx, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_READY_TIMEOUT)
			sm_ready_to = d;
		else
			sm_ack_to = d;
	endtask

	task automatic set_timeouts(input logic [15:0] rdy, input logic [15:0] ack);
		wait_drained();
		write_timeout(REG_READY_TIMEOUT, rdy);
		write_timeout(REG_ACK_TIMEOUT, ack);
	endtask

	// one word the current phase ignores or treats as a stray
	task automatic sprinkle();
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0: send_word(MODE_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
			1: send_word(MODE_RX, $urandom_range(0, 255), $urandom_range(0, 1));
			2: send_word(MODE_EOF, $urandom_range(0, 255), $urandom_range(0, 1));
			3: send_word(3'd6, $urandom_range(0, 255), $urandom_range(0, 1));
			4: send_word(3'd7, $urandom_range(0, 255), $urandom_range(0, 1));
			default: begin
				if (sm_phase != PH_LOAD_HEADER && sm_phase != PH_LOAD_CHUNK)
					send_word(MODE_PAYLOAD, $urandom_range(0, 255), $urandom_range(0, 1));
				else
					send_word(MODE_PULL, $urandom_range(0, 255), $urandom_range(0, 1));
			end
		endcase
	endtask

	// header or chunk bytes, with an occasional stray end of file word after the first byte
	task automatic load_bytes(input int n);
		for (int i = 0; i < n; i++) begin
			send_word(MODE_PAYLOAD, $urandom_range(0, 255), i == n - 1);
			if (i == 0 && n > 1 && $urandom_range(0, 7) == 0)
				send_word(MODE_EOF, $urandom_range(0, 255), 1'b0);
		end
	endtask

	task automatic pull_frame();
		while (sm_phase == PH_SEND_FRAME || sm_phase == PH_SEND_EOT) begin
			if ($urandom_range(0, 15) == 0)
				sprinkle();
			else
				send_word(MODE_PULL, $urandom_range(0, 255), $urandom_range(0, 1));
		end
	endtask

	// ticks and strays in a waiting phase, then the wanted byte or a timeout
	task automatic await_reply(input logic [7:0] want);
		int n;
		int lim;
		lim = (sm_phase == PH_WAIT_READY) ? sm_ready_to : sm_ack_to;
		n = $urandom_range(0, 3);
		repeat (n)
			send_word(MODE_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0)
			send_word(MODE_RX, $urandom_range(0, 255), $urandom_range(0, 1));
		if (lim <= 64 && $urandom_range(0, 7) == 0) begin
			while (sm_phase == PH_WAIT_READY || sm_phase == PH_WAIT_ACK)
				send_word(MODE_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
		end else begin
			send_word(MODE_RX, want, $urandom_range(0, 1));
		end
	endtask

	// one whole transfer, cut short wherever a timeout lands
	task automatic run_transfer(input int long_chunk);
		int n;
		int chunks;
		if (sm_phase != PH_LOAD_HEADER)
			send_word(MODE_RESTART, $urandom_range(0, 255), $urandom_range(0, 1));
		if ($urandom_range(0, 5) == 0)
			sprinkle();
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(129, 135) : $urandom_range(1, 12);
		load_bytes(n);
		await_reply(BYTE_C);
		if (sm_phase != PH_SEND_FRAME)
			return;
		pull_frame();
		await_reply(BYTE_ACK);
		if (sm_phase != PH_LOAD_CHUNK)
			return;
		chunks = $urandom_range(0, 2);
		repeat (chunks) begin
			n = ($urandom_range(0, 19) == 0) ? long_chunk : $urandom_range(1, 140);
			load_bytes(n);
			pull_frame();
			await_reply(BYTE_ACK);
			if (sm_phase != PH_LOAD_CHUNK)
				return;
		end
		send_word(MODE_EOF, $urandom_range(0, 255), $urandom_range(0, 1));
		pull_frame();
		await_reply(BYTE_ACK);
		if (sm_phase != PH_SEND_FRAME)
			return;
		pull_frame();
		sprinkle();
	endtask

	// full transfer with reset timeouts, a large frame and every stray kind
	task automatic test_directed_transfer();
		send_word(MODE_PULL, 8'h00, 1'b0);
		send_word(MODE_EOF, 8'hFF, 1'b1);
		send_word(MODE_RX, BYTE_C, 1'b0);
		send_word(MODE_TICK, 8'hFF, 1'b1);
		send_word(3'd6, 8'hAA, 1'b1);
		send_word(3'd7, 8'h55, 1'b0);
		send_word(MODE_PAYLOAD, 8'h00, 1'b0);
		send_word(MODE_PAYLOAD, 8'hFF, 1'b1);
		send_word(MODE_TICK, 8'h00, 1'b0);
		send_word(MODE_RX, 8'h15, 1'b0);
		send_word(MODE_RX, BYTE_C, 1'b0);
		pull_frame();
		send_word(MODE_RX, 8'h15, 1'b0);
		send_word(MODE_RX, BYTE_ACK, 1'b0);
		load_bytes(130);
		pull_frame();
		send_word(MODE_RX, BYTE_ACK, 1'b1);
		load_bytes(128);
		pull_frame();
		send_word(MODE_RX, BYTE_ACK, 1'b1);
		send_word(MODE_EOF, 8'h00, 1'b0);
		pull_frame();
		send_word(MODE_RX, BYTE_ACK, 1'b0);
		pull_frame();
		send_word(MODE_PULL, 8'h00, 1'b0);
		send_word(MODE_RX, BYTE_ACK, 1'b0);
		send_word(MODE_RESTART, 8'h00, 1'b0);
	endtask

	// shortest timeouts fail on the first tick of any wait
	task automatic test_short_timeouts();
		set_timeouts(16'd1, 16'd1);
		repeat (4) run_transfer(200);
	endtask

	// longest timeouts, never reached
	task automatic test_long_timeouts();
		set_timeouts(16'hFFFF, 16'hFFFF);
		repeat (1) run_transfer(140);
	endtask

	task automatic test_random_transfers();
		int base;
		base = words_sent;
		while (words_sent - base < 300) begin
			set_timeouts($urandom_range(1, 20), $urandom_range(1, 20));
			run_transfer(140);
		end
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_output_backpressure();
		wait_drained();
		hold_req = 1'b1;
		repeat (40) sprinkle();
	endtask

	// no idling on either side
	task automatic test_steady_stream();
		wait_drained();
		quiet = 1'b1;
		set_timeouts(16'd10, 16'd10);
		repeat (1) run_transfer(140);
	endtask

	// receiver side: random stalls and the long hold
	initial begin
		int gap;
		out_ready = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// compare each output word with the oldest expected one
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{tx_valid, tx_byte, status, fail_cause};
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word tx_valid=%0d tx_byte=%h status=%0d cause=%0d",
					$time, got.tx_valid, got.tx_byte, got.status, got.fail_cause);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected tx_valid=%0d tx_byte=%h status=%0d cause=%0d",
						$time, want.tx_valid, want.tx_byte, want.status, want.fail_cause);
					$display("%0t:          actual   tx_valid=%0d tx_byte=%h status=%0d cause=%0d",
						$time, got.tx_valid, got.tx_byte, got.status, got.fail_cause);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("%0t: timeout, %0d words still expected", $time, expected_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_TICK;
		value = 8'h00;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_READY_TIMEOUT;
		cfg_data = 16'h0000;
		errors = 0;
		words_sent = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		sm_ready_to = READY_TIMEOUT_RST;
		sm_ack_to = ACK_TIMEOUT_RST;
		for (int i = 0; i < LARGE_BLOCK_BYTES; i++)
			sm_chunk[i] = 8'h00;
		clear_sender();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_transfer();
		test_short_timeouts();
		test_output_backpressure();
		test_random_transfers();
		test_long_timeouts();
		test_steady_stream();

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ ymodem_crc_block_sender_core.f @@
+incdir+design
design/ycsb_pkg.sv
design/ycsb_ram.sv
design/ycsb_front.sv
design/ycsb_queue.sv
design/ycsb_back.sv
design/ymodem_crc_block_sender_core.sv
tb/testbench.sv
